>>> rtl/bqhp_pkg.sv
// bqhp_pkg: shared constants for the biquad high-pass filter
// register index codes, coefficient reset values and their scaling helper
// no dependencies
package bqhp_pkg;

	localparam int unsigned NUM_COEFS = 5;
	localparam int unsigned REG_IDX_W = 3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_COEF_B0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF_B1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEF_B2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEF_A1 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COEF_A2 = 3'd4;

	// default coefficients in q2.22
	localparam logic signed [63:0] B0_RST_Q22 = 64'sd4102157;
	localparam logic signed [63:0] B1_RST_Q22 = -64'sd8204314;
	localparam logic signed [63:0] B2_RST_Q22 = 64'sd4102157;
	localparam logic signed [63:0] A1_RST_Q22 = -64'sd8202290;
	localparam logic signed [63:0] A2_RST_Q22 = 64'sd4012035;

	localparam int unsigned BASE_FRAC = 22;

	// rescale a q2.22 value to another fraction width, ties toward plus infinity
	function automatic logic signed [63:0] scale_coef(input logic signed [63:0] v,
		input int unsigned frac);
		logic signed [63:0] r;
		if (frac >= BASE_FRAC) begin
			r = v <<< (frac - BASE_FRAC);
		end else begin
			r = (v + (64'sd1 <<< (BASE_FRAC - 1 - frac))) >>> (BASE_FRAC - frac);
		end
		return r;
	endfunction

endpackage

>>> rtl/bqhp_mac.sv
// bqhp_mac: five-tap multiply-accumulate with rounding and saturation
// purely combinational, sits between the input stage and the result register
// depends on nothing outside this file
module bqhp_mac #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 22
) (
	input  logic signed [SAMPLE_WIDTH-1:0]     x,
	input  logic signed [SAMPLE_WIDTH-1:0]     x1,
	input  logic signed [SAMPLE_WIDTH-1:0]     x2,
	input  logic signed [SAMPLE_WIDTH-1:0]     y1,
	input  logic signed [SAMPLE_WIDTH-1:0]     y2,
	input  logic signed [COEF_FRAC_BITS+1:0]   b0,
	input  logic signed [COEF_FRAC_BITS+1:0]   b1,
	input  logic signed [COEF_FRAC_BITS+1:0]   b2,
	input  logic signed [COEF_FRAC_BITS+1:0]   a1,
	input  logic signed [COEF_FRAC_BITS+1:0]   a2,
	output logic signed [SAMPLE_WIDTH-1:0]     y,
	output logic                               clip
);

	localparam int CW   = COEF_FRAC_BITS + 2;
	localparam int PW   = SAMPLE_WIDTH + CW;
	localparam int FULL = PW + 3;
	// accumulator wraps at 64 bits like the arithmetic it mirrors
	localparam int AW   = (FULL > 64) ? 64 : FULL;

	localparam logic signed [AW-1:0] RND  = AW'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [AW-1:0] YMAX =
		{{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [AW-1:0] YMIN = ~YMAX;

	logic signed [PW-1:0] p0, p1, p2, p3, p4;
	logic signed [AW-1:0] acc;
	logic signed [AW-1:0] y_full;

	assign p0 = b0 * x;
	assign p1 = b1 * x1;
	assign p2 = b2 * x2;
	assign p3 = a1 * y1;
	assign p4 = a2 * y2;

	assign acc = AW'(p0) + AW'(p1) + AW'(p2) - AW'(p3) - AW'(p4) + RND;
	assign y_full = acc >>> COEF_FRAC_BITS;

	always_comb begin
		priority if (y_full > YMAX) begin
			y    = YMAX[SAMPLE_WIDTH-1:0];
			clip = 1'b1;
		end else if (y_full < YMIN) begin
			y    = YMIN[SAMPLE_WIDTH-1:0];
			clip = 1'b1;
		end else begin
			y    = y_full[SAMPLE_WIDTH-1:0];
			clip = 1'b0;
		end
	end

endmodule

>>> rtl/biquad_iir_highpass.sv
// biquad_iir_highpass: second-order direct-form-1 iir filter, high-pass by default
// latency: each input beat passes the input stage, then the result register
// throughput: one beat per cycle while m_tready stays high; the feedback y1 -> y closes through one mac pass
// reset (arst_n low, async): history cleared, coefficients back to defaults, no beats held
// uses bqhp_pkg and bqhp_mac
module biquad_iir_highpass #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 22
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,   // sample_in
	input  logic                                s_tuser,   // buffer_start
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,   // sample_out
	output logic                                m_tuser,   // clipped
	// coefficient write port
	input  logic                                cfg_we,
	input  logic [bqhp_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [COEF_FRAC_BITS+1:0]           cfg_data
);

	import bqhp_pkg::*;

	localparam int SW  = SAMPLE_WIDTH;
	localparam int CW  = COEF_FRAC_BITS + 2;
	localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;

	// defaults rescaled to the configured fraction width
	localparam logic signed [63:0] B0_RST = scale_coef(B0_RST_Q22, COEF_FRAC_BITS);
	localparam logic signed [63:0] B1_RST = scale_coef(B1_RST_Q22, COEF_FRAC_BITS);
	localparam logic signed [63:0] B2_RST = scale_coef(B2_RST_Q22, COEF_FRAC_BITS);
	localparam logic signed [63:0] A1_RST = scale_coef(A1_RST_Q22, COEF_FRAC_BITS);
	localparam logic signed [63:0] A2_RST = scale_coef(A2_RST_Q22, COEF_FRAC_BITS);

	localparam logic signed [SW-1:0] YMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] YMIN = ~YMAX;

	// coefficient registers
	logic signed [CW-1:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;

	// input stage
	logic                 valid_s1;
	logic signed [SW-1:0] x_s1;
	logic                 start_s1;

	// filter history
	logic signed [SW-1:0] x1_q, x2_q, y1_q, y2_q;
	logic signed [SW-1:0] x1_eff, x2_eff, y1_eff, y2_eff;

	// result register
	logic                 out_valid_q;
	logic signed [SW-1:0] sample_out_q;
	logic                 clipped_q;

	logic                 advance;
	logic signed [SW-1:0] y_calc;
	logic                 clip_calc;

	// ---------------------------------------------------------------
	// coefficient writes, unknown indexes dropped
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q <= B0_RST[CW-1:0];
			coef_b1_q <= B1_RST[CW-1:0];
			coef_b2_q <= B2_RST[CW-1:0];
			coef_a1_q <= A1_RST[CW-1:0];
			coef_a2_q <= A2_RST[CW-1:0];
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF_B0: coef_b0_q <= cfg_data;
				REG_COEF_B1: coef_b1_q <= cfg_data;
				REG_COEF_B2: coef_b2_q <= cfg_data;
				REG_COEF_A1: coef_a1_q <= cfg_data;
				REG_COEF_A2: coef_a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// handshake: the stage moves into the result register whenever
	// that register is empty or being drained this cycle
	// ---------------------------------------------------------------
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_s1     <= s_tdata[SW-1:0];
			start_s1 <= s_tuser;
		end
	end

	// start of a buffer sees an all-zero past
	assign x1_eff = start_s1 ? '0 : x1_q;
	assign x2_eff = start_s1 ? '0 : x2_q;
	assign y1_eff = start_s1 ? '0 : y1_q;
	assign y2_eff = start_s1 ? '0 : y2_q;

	bqhp_mac #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.x    (x_s1),
		.x1   (x1_eff),
		.x2   (x2_eff),
		.y1   (y1_eff),
		.y2   (y2_eff),
		.b0   (coef_b0_q),
		.b1   (coef_b1_q),
		.b2   (coef_b2_q),
		.a1   (coef_a1_q),
		.a2   (coef_a2_q),
		.y    (y_calc),
		.clip (clip_calc)
	);

	// history shifts on the same edge as the result lands, so the next
	// beat in the stage already sees this output as y1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (advance) begin
			x1_q <= x_s1;
			x2_q <= x1_eff;
			y1_q <= y_calc;
			y2_q <= y1_eff;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_out_q <= y_calc;
			clipped_q    <= clip_calc;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDW'($unsigned(sample_out_q));
	assign m_tuser  = clipped_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && clipped_q |-> sample_out_q == YMAX || sample_out_q == YMIN)
		else $error("clipped beat not at a saturation rail");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && y1_q == sample_out_q)
		else $error("result register or y1 history not loaded on advance");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && start_s1 |=> x2_q == '0 && y2_q == '0)
		else $error("buffer start did not clear older history");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(x_s1) && $stable(start_s1))
		else $error("input stage changed while stalled");

endmodule

>>> dv/bqhp_filter_checker.sv
`timescale 1ns / 100ps
// bqhp_filter_checker: watches the sample, result and coefficient ports of the biquad
// keeps its own fixed-point filter, compares each output beat with the oldest expected one
// depends on bqhp_pkg for the register indexes and default coefficients
module bqhp_filter_checker #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 22
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,   // sample_in
	input  logic                                s_tuser,   // buffer_start
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,   // sample_out
	input  logic                                m_tuser,   // clipped
	input  logic                                cfg_we,
	input  logic [bqhp_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [COEF_FRAC_BITS+1:0]           cfg_data,
	output int                                  fail_count,
	output int                                  pending_count
);

	import bqhp_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int CF = COEF_FRAC_BITS;
	localparam int CW = COEF_FRAC_BITS + 2;
	localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam longint Y_MAX = (64'sd1 <<< (SW - 1)) - 1;
	localparam longint Y_MIN = -Y_MAX - 1;

	typedef struct packed {
		logic signed [SW-1:0] sample;
		logic                 clipped;
	} filter_result_t;

	logic signed [CW-1:0] coef [NUM_COEFS];
	logic signed [SW-1:0] x_hist_1, x_hist_2, y_hist_1, y_hist_2;
	filter_result_t       expected_q [$];
	int                   mismatches = 0;
	int                   pending = 0;

	assign fail_count    = mismatches;
	assign pending_count = pending;

	// defaults are q2.22, rescaled to the fraction width at reset
	function automatic longint default_q22(input int unsigned idx);
		case (idx)
			REG_COEF_B0: return B0_RST_Q22;
			REG_COEF_B1: return B1_RST_Q22;
			REG_COEF_B2: return B2_RST_Q22;
			REG_COEF_A1: return A1_RST_Q22;
			REG_COEF_A2: return A2_RST_Q22;
			default:     return 0;
		endcase
	endfunction

	// one filter step: history cleared on buffer start, full-precision sum, round half up, saturate, shift history
	function automatic filter_result_t filter_step(input logic signed [SW-1:0] x,
		input logic buffer_start);
		longint         acc;
		longint         y;
		filter_result_t r;
		if (buffer_start) begin
			x_hist_1 = '0;
			x_hist_2 = '0;
			y_hist_1 = '0;
			y_hist_2 = '0;
		end
		acc = longint'(coef[REG_COEF_B0]) * longint'(x)
			+ longint'(coef[REG_COEF_B1]) * longint'(x_hist_1)
			+ longint'(coef[REG_COEF_B2]) * longint'(x_hist_2)
			- longint'(coef[REG_COEF_A1]) * longint'(y_hist_1)
			- longint'(coef[REG_COEF_A2]) * longint'(y_hist_2);
		acc = acc + (64'sd1 <<< (CF - 1));
		y = acc >>> CF;
		r.clipped = 1'b0;
		if (y > Y_MAX) begin
			y = Y_MAX;
			r.clipped = 1'b1;
		end else if (y < Y_MIN) begin
			y = Y_MIN;
			r.clipped = 1'b1;
		end
		r.sample = SW'(y);
		x_hist_2 = x_hist_1;
		x_hist_1 = x;
		y_hist_2 = y_hist_1;
		y_hist_1 = r.sample;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input longint want, input longint got);
		if (mismatches < 10)
			$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		filter_result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++)
				coef[i] = CW'(scale_coef(default_q22(i), CF));
			x_hist_1 = '0;
			x_hist_2 = '0;
			y_hist_1 = '0;
			y_hist_2 = '0;
			expected_q.delete();
			pending = 0;
		end else begin
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected output beat, sample_out", 0,
						$signed(m_tdata[SW-1:0]));
				end else begin
					exp_r = expected_q.pop_front();
					if (m_tdata !== DW'($unsigned(exp_r.sample)))
						report_mismatch("sample_out", exp_r.sample, $signed(m_tdata[SW-1:0]));
					if (m_tuser !== exp_r.clipped)
						report_mismatch("clipped", exp_r.clipped, m_tuser);
				end
			end
			if (s_tvalid === 1'b1 && s_tready === 1'b1)
				expected_q.push_back(filter_step(s_tdata[SW-1:0], s_tuser));
			// writes past the last coefficient are dropped by the block
			if (cfg_we === 1'b1 && cfg_index < NUM_COEFS)
				coef[cfg_index] = cfg_data;
			pending = expected_q.size();
		end
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// testbench: stimulus and verdict for the biquad high-pass filter
// drives samples, back-pressure and coefficient sets; bqhp_filter_checker does the checking
// depends on bqhp_pkg, biquad_iir_highpass and bqhp_filter_checker
module testbench;
	import bqhp_pkg::*;

	localparam int SW = 16;
	localparam int CF = 22;
	localparam int CW = CF + 2;
	localparam int DW = ((SW + 7) / 8) * 8;
	localparam real CLK_PERIOD = 12.0;
	localparam int RANDOM_PER_PHASE = 275;
	// idle chance per cycle, in percent, on either side
	localparam int IDLE_PCT = 27;

	localparam logic signed [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] COEF_ONE = CW'(1) <<< CF;
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [DW-1:0]        s_tdata = '0;   // sample_in
	logic                 s_tuser = 1'b0; // buffer_start
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DW-1:0]        m_tdata;        // sample_out
	logic                 m_tuser;        // clipped
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CW-1:0]        cfg_data = '0;

	int                   fail_count;
	int                   pending_count;
	// set during the stretch where neither side idles
	logic                 steady = 1'b0;
	logic signed [SW-1:0] last_sample = '0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	biquad_iir_highpass #(
		.SAMPLE_WIDTH  (SW),
		.COEF_FRAC_BITS(CF)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	bqhp_filter_checker #(
		.SAMPLE_WIDTH  (SW),
		.COEF_FRAC_BITS(CF)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	// receiver back-pressure, changed on the falling edge only
	always @(negedge clk) begin
		m_tready = steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// single write on the coefficient port, one clock wide
	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CW-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// full coefficient set, plus writes to the unused indexes that must be dropped
	task automatic load_coefs(input logic signed [CW-1:0] b0, input logic signed [CW-1:0] b1,
		input logic signed [CW-1:0] b2, input logic signed [CW-1:0] a1,
		input logic signed [CW-1:0] a2);
		cfg_write(REG_COEF_B0, b0);
		cfg_write(REG_COEF_B1, b1);
		cfg_write(REG_COEF_B2, b2);
		cfg_write(REG_COEF_A1, a1);
		cfg_write(REG_COEF_A2, a2);
		for (int i = NUM_COEFS; i < (1 << REG_IDX_W); i++)
			cfg_write(REG_IDX_W'(i), CW'($urandom));
	endtask

	// one input beat: optional idle cycles first, then hold until accepted
	// tvalid stays high from beat to beat when no idle cycle falls between them
	task automatic send_sample(input logic signed [SW-1:0] x, input logic buffer_start);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid = 1'b0;
			s_tdata = DW'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = DW'($unsigned(x));
		s_tuser = buffer_start;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
		last_sample = x;
	endtask

	// sample mix: mostly full-range noise, with small values, rails, holds and zeros
	function automatic logic signed [SW-1:0] next_sample();
		case ($urandom_range(9))
			5, 6:    return SW'($signed($urandom_range(512)) - 256);
			7:       return $urandom_range(1) ? S_MAX : S_MIN;
			8:       return last_sample;
			9:       return '0;
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++)
			send_sample(next_sample(), $urandom_range(31) == 0);
	endtask

	// idle the input and let every expected output beat come out
	task automatic drain();
		s_tvalid = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_coef_set(input int span_bits);
		logic signed [CW-1:0] c [NUM_COEFS];
		for (int i = 0; i < NUM_COEFS; i++)
			c[i] = CW'($signed($urandom_range((1 << span_bits) - 1)) - (1 << (span_bits - 1)));
		load_coefs(c[0], c[1], c[2], c[3], c[4]);
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed beats on the reset coefficients
		send_sample('0, 1'b1);
		// full-scale alternation near nyquist drives the high-pass into both rails
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MAX, 1'b0);
		// buffer start right after clipping clears the whole history
		send_sample('0, 1'b1);
		send_sample(S_MIN, 1'b1);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MIN, 1'b0);
		// rounding around zero, then full-scale steps across buffer starts
		send_sample(SW'(1), 1'b1);
		send_sample(-SW'(1), 1'b0);
		send_sample('0, 1'b0);
		send_sample(SW'(2), 1'b0);
		send_sample(S_MAX, 1'b1);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b1);
		send_sample(S_MAX, 1'b0);
		run_random(RANDOM_PER_PHASE);
		drain();

		// every coefficient at the positive end: unstable loop, clips most beats
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		send_sample(S_MAX, 1'b1);
		send_sample(S_MIN, 1'b0);
		run_random(RANDOM_PER_PHASE);
		drain();

		// every coefficient at the negative end
		load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
		send_sample(S_MIN, 1'b1);
		send_sample(S_MAX, 1'b0);
		run_random(RANDOM_PER_PHASE);
		drain();

		// pass-through with no idling on either side
		load_coefs(COEF_ONE, '0, '0, '0, '0);
		steady = 1'b1;
		run_random(RANDOM_PER_PHASE);
		drain();
		steady = 1'b0;

		// full-range random coefficients
		random_coef_set(CW);
		run_random(RANDOM_PER_PHASE);
		drain();

		// moderate random coefficients, mostly non-clipping outputs
		random_coef_set(CF);
		run_random(RANDOM_PER_PHASE);
		drain();

		// reset coefficients written back explicitly
		load_coefs(CW'(B0_RST_Q22), CW'(B1_RST_Q22), CW'(B2_RST_Q22), CW'(A1_RST_Q22),
			CW'(A2_RST_Q22));
		run_random(RANDOM_PER_PHASE);
		drain();

		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#(CLK_PERIOD * 200000);
		$display("testbench NOT OK");
		$finish;
	end

endmodule
